@@ rtl/core/linear_interp_resampler_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the linear interpolation resampler RTL.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lir assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lir assertion failed");

`endif

@@ rtl/core/lir_pkg.sv @@
// ---------------------------------------------------------------------------
// lir_pkg
// Shared widths, reset values, register indexes and control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int STEP_W        = 18;
    localparam int PHASE_W       = 19;
    localparam int INDEX_W       = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_RUN_DEF   = 16;

    localparam logic [STEP_W-1:0]    STEP_RESET     = 18'h10000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEREO = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        logic last;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_lt_one;
        logic next_ge_one;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/linear_interp_resampler.sv @@
// ---------------------------------------------------------------------------
// linear_interp_resampler
// Streaming linear-interpolation sample-rate converter, mono or stereo.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one frame word: left and
//   right samples and a block-end flag. Output channel (o_out_valid /
//   i_out_stall) delivers interpolated frame words with a last-of-run flag
//   and the index of the word within the current block.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes step at
//   index 0 and stereo at index 1; write only while the block is idle.
// Sequencing:
//   A frame producing n words is first taken into the current-frame
//   registers; its run then emits one output word per cycle while the
//   receiver does not stall, each computed by the interpolation unit and
//   registered in the output word register. n is at most MAX_RUN.
//   o_in_stall is high from the cycle after a frame is taken until its run
//   finishes. When the receiver stalls, the output word holds and the run
//   pauses. Reset sets step to 1.0, stereo on, history to zero and the
//   phase to 1.0, so the first frame only primes the history.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN   = lir_pkg::MAX_RUN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lir_pkg::STEP_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] i_right_in,
    input  wire logic                                i_block_end,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      o_left_out,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      o_right_out,
    output logic                                     o_last_of_run,
    output logic [lir_pkg::INDEX_W-1:0]              o_index_in_block
);
    import lir_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lir_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lir_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_block_end      (i_block_end),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_last_of_run    (o_last_of_run),
        .o_index_in_block (o_index_in_block)
    );

endmodule

`default_nettype wire

@@ rtl/core/lir_dp.sv @@
// ---------------------------------------------------------------------------
// lir_dp
// Datapath: configuration, history frame, phase accumulator, interpolation
// multipliers and the output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [lir_pkg::STEP_W-1:0]             i_cfg_data,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0]    i_left_in,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0]    i_right_in,
    input  wire logic                                   i_block_end,
    input  wire logic                                   i_out_stall,
    input  wire lir_pkg::t_dp_cmd                       i_cmd,
    output lir_pkg::t_dp_sts                            o_sts,
    output logic                                        o_out_valid,
    output logic signed [lir_pkg::SAMPLE_W-1:0]         o_left_out,
    output logic signed [lir_pkg::SAMPLE_W-1:0]         o_right_out,
    output logic                                        o_last_of_run,
    output logic [lir_pkg::INDEX_W-1:0]                 o_index_in_block
);
    import lir_pkg::*;

    localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FRAC_BITS;

    logic [STEP_W-1:0]          r_step;
    logic                       r_stereo;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r;
    logic signed [SAMPLE_W-1:0] r_cur_l, r_cur_r;
    logic                       r_blk_end;
    logic [PHASE_W-1:0]         r_phase;
    logic [INDEX_W-1:0]         r_count;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;
    logic                       r_out_last;
    logic [INDEX_W-1:0]         r_out_idx;

    logic [PHASE_W-1:0]         w_phase_next;
    logic [PHASE_W-1:0]         w_base;
    logic [PHASE_W-1:0]         w_phase_final;
    logic [FRAC_BITS-1:0]       w_t;
    logic signed [SAMPLE_W-1:0] w_interp_l, w_interp_r;

    // prev + floor((cur - prev) * t / ONE) equals the weighted sum floored.
    function automatic logic signed [SAMPLE_W-1:0] interp(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRAC_BITS-1:0]       t
    );
        logic signed [SAMPLE_W:0]           d;
        logic signed [FRAC_BITS:0]          ts;
        logic signed [SAMPLE_W+FRAC_BITS+1:0] p;
        logic signed [SAMPLE_W+1:0]         q;
        logic signed [SAMPLE_W+1:0]         s;
        d  = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);
        ts = $signed({1'b0, t});
        p  = d * ts;
        q  = (SAMPLE_W+2)'(p >>> FRAC_BITS);
        s  = q + (SAMPLE_W+2)'(a);
        return s[SAMPLE_W-1:0];
    endfunction

    assign w_t          = r_phase[FRAC_BITS-1:0];
    assign w_phase_next = r_phase + PHASE_W'(r_step);
    assign w_base       = i_cmd.emit ? w_phase_next : r_phase;
    // A run cut short by the cap leaves the phase below one; it saturates to 0.
    assign w_phase_final = (w_base >= ONE) ? (w_base - ONE) : '0;
    assign w_interp_l   = interp(r_prev_l, r_cur_l, w_t);
    assign w_interp_r   = r_stereo ? interp(r_prev_r, r_cur_r, w_t) : '0;

    assign o_sts.phase_lt_one = (r_phase < ONE);
    assign o_sts.next_ge_one  = (w_phase_next >= ONE);
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_stereo    <= 1'b1;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_phase     <= ONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_STEP:   r_step   <= i_cfg_data;
                    CFG_IDX_STEREO: r_stereo <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_phase     <= w_phase_next;
                r_count     <= r_count + INDEX_W'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_phase  <= w_phase_final;
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
                if (r_blk_end) begin
                    r_count <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_l   <= i_left_in;
            r_cur_r   <= i_right_in;
            r_blk_end <= i_block_end;
        end
        if (i_cmd.emit) begin
            r_out_l    <= w_interp_l;
            r_out_r    <= w_interp_r;
            r_out_last <= i_cmd.last;
            r_out_idx  <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_out       = r_out_l;
    assign o_right_out      = r_out_r;
    assign o_last_of_run    = r_out_last;
    assign o_index_in_block = r_out_idx;

endmodule

`default_nettype wire

@@ rtl/core/lir_ctrl.sv @@
// ---------------------------------------------------------------------------
// lir_ctrl
// Controller: takes one input word, then sequences the run of outputs and
// the phase wrap at its end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_interp_resampler_defines.svh"

module lir_ctrl #(
    parameter int MAX_RUN = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire lir_pkg::t_dp_sts i_sts,
    output lir_pkg::t_dp_cmd      o_cmd
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RUN - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_run_cnt, n_run_cnt;
    logic             w_last;

    assign w_last = i_sts.next_ge_one || (r_run_cnt == CNT_LAST);

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_run_cnt = r_run_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_run_cnt  = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.phase_lt_one) begin
                    // No output for this frame: wrap the phase and store history.
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_last;
                    if (w_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_run_cnt = r_run_cnt + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_run_cnt <= n_run_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `LIR_ASSERT_IMPLIES(a_emit_only_when_free, i_clk, i_rst_n, o_cmd.emit, (r_state == S_RUN) && i_sts.out_free)
    `LIR_ASSERT_IMPLIES(a_load_only_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `LIR_ASSERT_IMPLIES(a_run_cap, i_clk, i_rst_n, r_state == S_RUN, r_run_cnt <= CNT_LAST)
    `LIR_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, o_cmd.finish, r_state == S_IDLE)

endmodule

`default_nettype wire
